/* src/vramp_pkg.sv */
// Shared types and constants for the four-axis velocity ramp.
`default_nettype none
package vramp_pkg;

    localparam int CFG_W      = 23;
    localparam int CFG_ADDR_W = 4;
    localparam int NUM_AXES   = 4;
    localparam int OUT_AXIS   = 3;

    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    typedef struct packed {
        cfg_word_t accel;
        cfg_word_t drag;
        cfg_word_t brake;
        cfg_word_t max_speed;
    } ramp_params_t;

    // Configuration register indexes
    localparam cfg_addr_t REG_PLANAR_ACCEL  = 4'd0;
    localparam cfg_addr_t REG_PLANAR_DRAG   = 4'd1;
    localparam cfg_addr_t REG_PLANAR_BRAKE  = 4'd2;
    localparam cfg_addr_t REG_PLANAR_MAX    = 4'd3;
    localparam cfg_addr_t REG_OUTWARD_ACCEL = 4'd4;
    localparam cfg_addr_t REG_OUTWARD_DRAG  = 4'd5;
    localparam cfg_addr_t REG_OUTWARD_BRAKE = 4'd6;
    localparam cfg_addr_t REG_OUTWARD_MAX   = 4'd7;

    // Reset values
    localparam cfg_word_t RST_PLANAR_ACCEL  = 23'd19661;
    localparam cfg_word_t RST_PLANAR_DRAG   = 23'd9830;
    localparam cfg_word_t RST_PLANAR_BRAKE  = 23'd16384;
    localparam cfg_word_t RST_PLANAR_MAX    = 23'd196608;
    localparam cfg_word_t RST_OUTWARD_ACCEL = 23'd32768;
    localparam cfg_word_t RST_OUTWARD_DRAG  = 23'd16384;
    localparam cfg_word_t RST_OUTWARD_BRAKE = 23'd32768;
    localparam cfg_word_t RST_OUTWARD_MAX   = 23'd65536;

    // Item kinds
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Direction command codes; the remaining pattern is invalid
    localparam logic [1:0] DIR_ZERO    = 2'b00;
    localparam logic [1:0] DIR_POS     = 2'b01;
    localparam logic [1:0] DIR_INVALID = 2'b10;
    localparam logic [1:0] DIR_NEG     = 2'b11;

endpackage
`default_nettype wire

/* src/vramp_cfg.sv */
// Configuration register file: planar and outward ramp parameters.
`default_nettype none
module vramp_cfg
    import vramp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    input  wire cfg_addr_t    cfg_addr,
    input  wire cfg_word_t    cfg_data,
    output ramp_params_t      planar,
    output ramp_params_t      outward
);

    ramp_params_t planar_reg;
    ramp_params_t outward_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planar_reg.accel      <= RST_PLANAR_ACCEL;
            planar_reg.drag       <= RST_PLANAR_DRAG;
            planar_reg.brake      <= RST_PLANAR_BRAKE;
            planar_reg.max_speed  <= RST_PLANAR_MAX;
            outward_reg.accel     <= RST_OUTWARD_ACCEL;
            outward_reg.drag      <= RST_OUTWARD_DRAG;
            outward_reg.brake     <= RST_OUTWARD_BRAKE;
            outward_reg.max_speed <= RST_OUTWARD_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_PLANAR_ACCEL:  planar_reg.accel      <= cfg_data;
                REG_PLANAR_DRAG:   planar_reg.drag       <= cfg_data;
                REG_PLANAR_BRAKE:  planar_reg.brake      <= cfg_data;
                REG_PLANAR_MAX:    planar_reg.max_speed  <= cfg_data;
                REG_OUTWARD_ACCEL: outward_reg.accel     <= cfg_data;
                REG_OUTWARD_DRAG:  outward_reg.drag      <= cfg_data;
                REG_OUTWARD_BRAKE: outward_reg.brake     <= cfg_data;
                REG_OUTWARD_MAX:   outward_reg.max_speed <= cfg_data;
                default: ;
            endcase
        end
    end

    assign planar  = planar_reg;
    assign outward = outward_reg;

endmodule
`default_nettype wire

/* src/vramp_lane.sv */
// One axis update: accelerate and clamp, brake, or drag toward zero.
`default_nettype none
module vramp_lane
    import vramp_pkg::*;
#(
    parameter int SPEED_BITS = 24
) (
    input  wire logic signed [SPEED_BITS-1:0] speed,
    input  wire logic [1:0]                   command,
    input  wire ramp_params_t                 params,
    output logic signed [SPEED_BITS-1:0]      speed_next,
    output logic [1:0]                        command_next
);

    localparam int EW = ((SPEED_BITS > CFG_W) ? SPEED_BITS : CFG_W) + 2;
    localparam logic signed [EW-1:0] SPEED_HI =
        {{(EW-SPEED_BITS+1){1'b0}}, {(SPEED_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] SPEED_LO =
        {{(EW-SPEED_BITS+1){1'b1}}, {(SPEED_BITS-1){1'b0}}};

    logic signed [EW-1:0] v;
    logic signed [EW-1:0] acc;
    logic signed [EW-1:0] drg;
    logic signed [EW-1:0] brk;
    logic signed [EW-1:0] lim;
    logic signed [EW-1:0] sum_up;
    logic signed [EW-1:0] sum_dn;
    logic signed [EW-1:0] res;

    function automatic logic signed [EW-1:0] toward_zero(
        input logic signed [EW-1:0] val,
        input logic signed [EW-1:0] step
    );
        logic signed [EW-1:0] dec;
        logic signed [EW-1:0] inc;
        dec = val - step;
        inc = val + step;
        if (val > 0)
            toward_zero = (dec > 0) ? dec : '0;
        else if (val < 0)
            toward_zero = (inc < 0) ? inc : '0;
        else
            toward_zero = '0;
    endfunction

    assign v      = {{(EW-SPEED_BITS){speed[SPEED_BITS-1]}}, speed};
    assign acc    = {{(EW-CFG_W){1'b0}}, params.accel};
    assign drg    = {{(EW-CFG_W){1'b0}}, params.drag};
    assign brk    = {{(EW-CFG_W){1'b0}}, params.brake};
    assign lim    = {{(EW-CFG_W){1'b0}}, params.max_speed};
    assign sum_up = v + acc;
    assign sum_dn = v - acc;

    always_comb begin
        command_next = command;
        res          = v;
        if (command == DIR_ZERO) begin
            res = toward_zero(v, drg);
        end else if (v == 0 || v[EW-1] == command[1]) begin
            // same sign or from rest: accelerate, snap to the limit
            if (!command[1])
                res = (sum_up > lim) ? lim : sum_up;
            else
                res = (sum_dn < -lim) ? -lim : sum_dn;
        end else begin
            res = toward_zero(v, brk);
            if (res == 0)
                command_next = DIR_ZERO;
        end

        if (res > SPEED_HI)
            speed_next = SPEED_HI[SPEED_BITS-1:0];
        else if (res < SPEED_LO)
            speed_next = SPEED_LO[SPEED_BITS-1:0];
        else
            speed_next = res[SPEED_BITS-1:0];
    end

endmodule
`default_nettype wire

/* src/axis_velocity_ramp.sv */
// An accepted beat is held in the input register; its result is then registered in
// the result register that drives m_axis.
// Throughput: one beat per cycle; the input register refills while the result
// register holds, so a stalled output blocks the input only once both are full.
// On a tick, all four axes update in one pass through four parallel lanes.
// Reset (aresetn low, synchronous): speeds and commands clear, registers take
// their default values, both stages empty.
`default_nettype none
module axis_velocity_ramp
    import vramp_pkg::*;
#(
    parameter int SPEED_BITS = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // tdata: axis[1:0], direction[3:2], zero pad
    input  wire logic [7:0]              s_axis_tdata,
    // tuser: op
    input  wire logic                    s_axis_tuser,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: speed_forward, speed_right, speed_up, speed_out, command_forward,
    // command_right, command_up, command_out, moving, zero pad
    output logic [((4*SPEED_BITS+9+7)/8)*8-1:0] m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire cfg_addr_t               cfg_addr,
    input  wire cfg_word_t               cfg_data
);

    localparam int OUT_W   = ((4*SPEED_BITS+9+7)/8)*8;
    localparam int CMD_LSB = NUM_AXES*SPEED_BITS;
    localparam int MOV_BIT = CMD_LSB + 2*NUM_AXES;

    ramp_params_t planar;
    ramp_params_t outward;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [1:0] in_axis_reg;
    logic [1:0] in_dir_reg;

    logic signed [SPEED_BITS-1:0] speed_reg [NUM_AXES];
    logic [1:0]                   command_reg [NUM_AXES];
    logic signed [SPEED_BITS-1:0] speed_next [NUM_AXES];
    logic [1:0]                   command_next [NUM_AXES];
    logic signed [SPEED_BITS-1:0] lane_speed [NUM_AXES];
    logic [1:0]                   lane_command [NUM_AXES];

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic [OUT_W-1:0] out_data;
    logic             advance;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    vramp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .planar    (planar),
        .outward   (outward)
    );

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        vramp_lane #(.SPEED_BITS(SPEED_BITS)) u_lane (
            .speed        (speed_reg[i]),
            .command      (command_reg[i]),
            .params       ((i == OUT_AXIS) ? outward : planar),
            .speed_next   (lane_speed[i]),
            .command_next (lane_command[i])
        );
    end

    always_comb begin
        out_data = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            speed_next[i]   = speed_reg[i];
            command_next[i] = command_reg[i];
            if (in_op_reg == OP_TICK) begin
                speed_next[i]   = lane_speed[i];
                command_next[i] = lane_command[i];
            end else if (in_axis_reg == 2'(i) && in_dir_reg != DIR_INVALID) begin
                command_next[i] = in_dir_reg;
            end
            out_data[i*SPEED_BITS +: SPEED_BITS] = speed_next[i];
            out_data[CMD_LSB + 2*i +: 2]         = command_next[i];
            if (speed_next[i] != 0)
                out_data[MOV_BIT] = 1'b1;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg   <= s_axis_tuser;
            in_axis_reg <= s_axis_tdata[1:0];
            in_dir_reg  <= s_axis_tdata[3:2];
        end
    end

    // state and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                speed_reg[i]   <= '0;
                command_reg[i] <= DIR_ZERO;
            end
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_AXES; i++) begin
                    speed_reg[i]   <= speed_next[i];
                    command_reg[i] <= command_next[i];
                end
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance)
            m_data_reg <= out_data;
    end

endmodule
`default_nettype wire

/* src/vramp_checker.sv */
// Port-level checks for the velocity ramp, bound to the top level.
`default_nettype none
module vramp_checker
    import vramp_pkg::*;
#(
    parameter int SPEED_BITS = 24
) (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic [((4*SPEED_BITS+9+7)/8)*8-1:0]    m_axis_tdata,
    input wire logic                                   m_axis_tvalid,
    input wire logic                                   m_axis_tready
);

    localparam int CMD_LSB = 4*SPEED_BITS;
    localparam int MOV_BIT = CMD_LSB + 8;

    logic any_speed;
    assign any_speed = (m_axis_tdata[CMD_LSB-1:0] != '0);

    a_out_empty_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !m_axis_tvalid
    ) else $error("result valid right after reset");

    a_hold_stalled: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    ) else $error("stalled result changed");

    a_moving_flag: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[MOV_BIT] == any_speed
    ) else $error("moving flag disagrees with speeds");

    a_command_codes: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[CMD_LSB+1 -: 2] != DIR_INVALID
            && m_axis_tdata[CMD_LSB+3 -: 2] != DIR_INVALID
            && m_axis_tdata[CMD_LSB+5 -: 2] != DIR_INVALID
            && m_axis_tdata[CMD_LSB+7 -: 2] != DIR_INVALID
    ) else $error("invalid direction command in result");

endmodule

bind axis_velocity_ramp vramp_checker #(.SPEED_BITS(SPEED_BITS)) u_vramp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
`default_nettype wire
